>>> src/bpf_pkg.sv
// shared types and constants of the bezier path flattener
`default_nettype none

package bpf_pkg;

   // width of one Q16.16 coordinate
   localparam int COORD_W = 32;

   // path command codes carried on the request tuser
   typedef enum logic [1:0] {
      CMD_MOVE  = 2'd0,
      CMD_LINE  = 2'd1,
      CMD_QUAD  = 2'd2,
      CMD_CUBIC = 2'd3
   } cmd_type;

endpackage

`default_nettype wire

>>> src/bezier_path_flattener_core.sv
// bezier path flattener: move, line, quadratic and cubic path commands to points
//
// channel  dir  handshake                 payload
// req      in   req_tvalid / req_tready   tuser: command, tdata: p1..p3 (x, y)
// rsp      out  rsp_tvalid / rsp_tready   tuser: new_subpath, tlast: last, tdata: x, y
//
// a move or line word gives one point, which shows on rsp in the cycle after it is taken.
// a curve gives SEGMENTS+1 points; for each point, per axis, four products go
// through the one shared multiplier, then one sum, one bias add and two 16-bit
// quotient digits, each by reciprocal estimate, back multiply, subtract and two
// compare-and-subtract corrections; then the point is posted. no new request
// word is taken until the last point of the curve has been posted.
// reset clears the current point to (0,0) and the path to empty.
// a stalled rsp side holds the sequencer in its post step; a request word is taken
// only while the sequencer is idle and the output register is empty or draining.
`default_nettype none

module bezier_path_flattener_core #(
   parameter int SEGMENTS = 10
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [1:0]   req_tuser,   // [1:0] command
   input  wire logic [191:0] req_tdata,   // p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
   // response channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic              rsp_tuser,   // [0] new_subpath
   output logic              rsp_tlast,
   output logic [63:0]       rsp_tdata    // out_x, out_y
);

   localparam int CW  = $clog2(SEGMENTS * SEGMENTS * SEGMENTS + 1);
   localparam int KW  = $clog2(SEGMENTS + 1);
   localparam int PW  = bpf_pkg::COORD_W;
   localparam int AW  = CW + PW + 1;
   localparam int DVW = CW + PW;
   localparam int HW  = PW / 2;
   localparam int NW  = CW + HW;
   localparam int XW  = HW + 1;
   localparam int MA  = (CW > HW + 2) ? CW : HW + 2;
   localparam int MW  = MA + PW + 1;
   localparam int RW  = CW + 2;
   localparam logic [CW-1:0] DEN = CW'(SEGMENTS * SEGMENTS * SEGMENTS);
   localparam logic [RW-1:0] DEN_R = RW'(SEGMENTS * SEGMENTS * SEGMENTS);
   // den/2 for rounding plus den * 2^31 to make the dividend non-negative
   localparam longint BIAS_L = longint'(SEGMENTS * SEGMENTS * SEGMENTS) * 64'sd2147483648
                               + longint'((SEGMENTS * SEGMENTS * SEGMENTS) / 2);
   localparam logic [AW-1:0] BIAS = AW'(BIAS_L);
   // reciprocal of the denominator for one 16-bit quotient digit
   localparam longint MU_L = (64'sd1 <<< (CW + HW))
                             / longint'(SEGMENTS * SEGMENTS * SEGMENTS);
   localparam logic [MA-1:0] MU = MA'(MU_L);
   localparam logic [KW-1:0] K_LAST = KW'(SEGMENTS);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_SUM,
      S_PREP,
      S_EST,
      S_QD,
      S_SUB,
      S_FIX,
      S_EMIT
   } state_type;

   state_type         state_ff;
   logic [KW-1:0]     k_ff;
   logic [1:0]        term_ff;
   logic              axis_ff;
   logic              cubic_ff;
   logic              digit_ff;
   logic [PW-1:0]     pts_x_ff [4];
   logic [PW-1:0]     pts_y_ff [4];
   logic [PW-1:0]     cur_x_ff;
   logic [PW-1:0]     cur_y_ff;
   logic              nonempty_ff;
   logic [MW-1:0]     prod_ff;
   logic [AW-1:0]     acc_ff;
   logic [CW-1:0]     rem_ff;
   logic [PW-1:0]     quo_ff;
   logic [HW-1:0]     qdig_ff;
   logic [RW-1:0]     wrem_ff;
   logic [PW-1:0]     res_x_ff;
   logic [PW-1:0]     res_y_ff;
   logic              rsp_valid_ff;
   logic              rsp_sub_ff;
   logic              rsp_last_ff;
   logic [2*PW-1:0]   rsp_data_ff;

   logic [CW-1:0]     coef_tab [2][SEGMENTS+1][4];
   logic [CW-1:0]     coef;
   logic [PW-1:0]     pt_sel;
   logic [MA-1:0]     mul_a;
   logic [PW-1:0]     mul_b;
   logic [MW-1:0]     mul_p;
   logic [AW-1:0]     biased;
   logic [NW-1:0]     numer;
   logic [XW-1:0]     x_hi;
   logic [HW-1:0]     q_est;
   logic [NW-1:0]     diff;
   logic              fix1;
   logic [RW-1:0]     wrem_mid;
   logic              fix2;
   logic [RW-1:0]     wrem_end;
   logic [HW-1:0]     q_fix;
   logic [PW-1:0]     quo_next;
   logic              out_free;
   logic              post_pt;
   bpf_pkg::cmd_type  cmd;

   // bernstein weights per step, all scaled to a common denominator of n^3
   for (genvar gk = 0; gk <= SEGMENTS; gk++) begin : g_coef
      localparam int J = SEGMENTS - gk;
      assign coef_tab[0][gk][0] = CW'(SEGMENTS * J * J);
      assign coef_tab[0][gk][1] = CW'(2 * SEGMENTS * gk * J);
      assign coef_tab[0][gk][2] = CW'(SEGMENTS * gk * gk);
      assign coef_tab[0][gk][3] = '0;
      assign coef_tab[1][gk][0] = CW'(J * J * J);
      assign coef_tab[1][gk][1] = CW'(3 * gk * J * J);
      assign coef_tab[1][gk][2] = CW'(3 * gk * gk * J);
      assign coef_tab[1][gk][3] = CW'(gk * gk * gk);
   end

   assign coef   = coef_tab[cubic_ff][k_ff][term_ff];
   assign pt_sel = axis_ff ? pts_y_ff[term_ff] : pts_x_ff[term_ff];

   // shared multiplier operands: weighted points, reciprocal estimate, back multiply
   always_comb begin
      unique case (state_ff)
         S_EST: begin
            mul_a = MU;
            mul_b = PW'(x_hi);
         end
         S_QD: begin
            mul_a = MA'(DEN);
            mul_b = PW'(q_est);
         end
         default: begin
            mul_a = MA'(coef);
            mul_b = pt_sel;
         end
      endcase
   end

   // unsigned a times signed b
   assign mul_p = $signed({{PW{1'b0}}, 1'b0, mul_a}) * $signed({{(MA + 1){mul_b[PW-1]}}, mul_b});

   // rounding and sign bias ahead of the divider
   assign biased = acc_ff + BIAS;

   // one quotient digit: running remainder with the next 16 dividend bits
   assign numer = {rem_ff, quo_ff[PW-1:HW]};
   assign x_hi  = numer[NW-1:CW-1];
   assign q_est = prod_ff[XW+HW-1:XW];
   assign diff  = numer - prod_ff[NW-1:0];

   // the estimate is at most two low, so two compare-and-subtract steps
   assign fix1     = wrem_ff >= DEN_R;
   assign wrem_mid = fix1 ? wrem_ff - DEN_R : wrem_ff;
   assign fix2     = wrem_mid >= DEN_R;
   assign wrem_end = fix2 ? wrem_mid - DEN_R : wrem_mid;
   assign q_fix    = qdig_ff + HW'(fix1) + HW'(fix2);
   assign quo_next = {quo_ff[HW-1:0], q_fix};

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign cmd        = bpf_pkg::cmd_type'(req_tuser);
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign post_pt    = ((state_ff == S_IDLE) && req_tvalid && req_tready
                        && (cmd == bpf_pkg::CMD_MOVE || cmd == bpf_pkg::CMD_LINE))
                       || ((state_ff == S_EMIT) && out_free);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_sub_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = rsp_data_ff;

   // sequencer, datapath registers and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         k_ff         <= '0;
         term_ff      <= '0;
         axis_ff      <= 1'b0;
         digit_ff     <= 1'b0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         nonempty_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (post_pt) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  nonempty_ff <= 1'b1;
                  if (cmd == bpf_pkg::CMD_MOVE || cmd == bpf_pkg::CMD_LINE) begin
                     rsp_sub_ff   <= (cmd == bpf_pkg::CMD_MOVE) && nonempty_ff;
                     rsp_last_ff  <= 1'b1;
                     rsp_data_ff  <= req_tdata[2*PW-1:0];
                     cur_x_ff     <= req_tdata[PW-1:0];
                     cur_y_ff     <= req_tdata[2*PW-1:PW];
                  end else begin
                     pts_x_ff[0] <= cur_x_ff;
                     pts_y_ff[0] <= cur_y_ff;
                     pts_x_ff[1] <= req_tdata[PW-1:0];
                     pts_y_ff[1] <= req_tdata[2*PW-1:PW];
                     pts_x_ff[2] <= req_tdata[3*PW-1:2*PW];
                     pts_y_ff[2] <= req_tdata[4*PW-1:3*PW];
                     pts_x_ff[3] <= req_tdata[5*PW-1:4*PW];
                     pts_y_ff[3] <= req_tdata[6*PW-1:5*PW];
                     cubic_ff    <= (cmd == bpf_pkg::CMD_CUBIC);
                     k_ff        <= '0;
                     term_ff     <= '0;
                     axis_ff     <= 1'b0;
                     state_ff    <= S_MUL;
                  end
               end
            end
            S_MUL: begin
               prod_ff <= mul_p;
               acc_ff  <= (term_ff == 2'd0) ? '0 : acc_ff + prod_ff[AW-1:0];
               term_ff <= term_ff + 2'd1;
               if (term_ff == 2'd3) begin
                  state_ff <= S_SUM;
               end
            end
            S_SUM: begin
               acc_ff   <= acc_ff + prod_ff[AW-1:0];
               state_ff <= S_PREP;
            end
            S_PREP: begin
               rem_ff   <= biased[DVW-1:PW];
               quo_ff   <= biased[PW-1:0];
               digit_ff <= 1'b0;
               state_ff <= S_EST;
            end
            S_EST: begin
               prod_ff  <= mul_p;
               state_ff <= S_QD;
            end
            S_QD: begin
               qdig_ff  <= q_est;
               prod_ff  <= mul_p;
               state_ff <= S_SUB;
            end
            S_SUB: begin
               wrem_ff  <= diff[RW-1:0];
               state_ff <= S_FIX;
            end
            S_FIX: begin
               rem_ff   <= wrem_end[CW-1:0];
               quo_ff   <= quo_next;
               digit_ff <= 1'b1;
               if (!digit_ff) begin
                  state_ff <= S_EST;
               end else if (!axis_ff) begin
                  // undo the sign bias by flipping the top quotient bit
                  res_x_ff <= {~quo_next[PW-1], quo_next[PW-2:0]};
                  axis_ff  <= 1'b1;
                  term_ff  <= '0;
                  state_ff <= S_MUL;
               end else begin
                  res_y_ff <= {~quo_next[PW-1], quo_next[PW-2:0]};
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_sub_ff   <= 1'b0;
                  rsp_last_ff  <= (k_ff == K_LAST);
                  rsp_data_ff  <= {res_y_ff, res_x_ff};
                  if (k_ff == K_LAST) begin
                     cur_x_ff <= res_x_ff;
                     cur_y_ff <= res_y_ff;
                     state_ff <= S_IDLE;
                  end else begin
                     k_ff     <= k_ff + 1'b1;
                     axis_ff  <= 1'b0;
                     term_ff  <= '0;
                     state_ff <= S_MUL;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // a new command never overwrites a point still waiting on the response side
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !(rsp_tvalid && !rsp_tready))
      else $error("request taken while a point is stalled");

   // only single-point moves carry the subpath mark
   a_sub_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("subpath mark on a point that is not the last");

   // running remainder stays below the denominator
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EST) |-> (rem_ff < DEN))
      else $error("divider remainder out of range");

   // step index never passes the segment count
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      k_ff <= K_LAST)
      else $error("step index beyond the last segment");

   // a point is posted only after both axes have gone through the divider
   a_emit_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) && !$past(state_ff == S_EMIT) |-> $past(state_ff == S_FIX) && axis_ff)
      else $error("point posted before both axes were divided");

endmodule

`default_nettype wire
